FILE: rtl/core/bsalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsalu_pkg
// Shared types, field widths and the condition check for the
// data-processing execute unit with barrel shifter and NZCV flags.
// ----------------------------------------------------------------------------
package bsalu_pkg;

    // stream widths: request word in, packed result out (43 bits padded to 48)
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    localparam int XLEN    = 32;
    localparam int NUM_REGS = 16;
    localparam int REG_IDX_W = 4;
    localparam int FLAGS_W = 4;

    // program counter value after reset (current address plus eight)
    localparam logic [XLEN-1:0] PC_RESET = 32'd8;
    localparam logic [XLEN-1:0] PC_STEP  = 32'd4;
    localparam logic [XLEN-1:0] PC_AHEAD = 32'd8;
    localparam logic [REG_IDX_W-1:0] PC_IDX = 4'd15;

    // alu opcodes
    typedef enum logic [3:0] {
        OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
        OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
        OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
        OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
    } alu_op_t;

    // shift kinds
    typedef enum logic [1:0] {
        SH_LSL = 2'd0, SH_LSR = 2'd1, SH_ASR = 2'd2, SH_ROR = 2'd3
    } shift_t;

    // condition codes
    typedef enum logic [3:0] {
        CC_EQ = 4'd0,  CC_NE = 4'd1,  CC_CS = 4'd2,  CC_CC = 4'd3,
        CC_MI = 4'd4,  CC_PL = 4'd5,  CC_VS = 4'd6,  CC_VC = 4'd7,
        CC_HI = 4'd8,  CC_LS = 4'd9,  CC_GE = 4'd10, CC_LT = 4'd11,
        CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
    } cond_t;

    // condition check against NZCV (N in bit 3)
    function automatic logic cond_pass(input logic [3:0] cond, input logic [FLAGS_W-1:0] f);
        logic n, z, c, v, p;
        n = f[3];
        z = f[2];
        c = f[1];
        v = f[0];
        case (cond_t'(cond))
            CC_EQ:   p = z;
            CC_NE:   p = !z;
            CC_CS:   p = c;
            CC_CC:   p = !c;
            CC_MI:   p = n;
            CC_PL:   p = !n;
            CC_VS:   p = v;
            CC_VC:   p = !v;
            CC_HI:   p = c && !z;
            CC_LS:   p = !c || z;
            CC_GE:   p = (n == v);
            CC_LT:   p = (n != v);
            CC_GT:   p = !z && (n == v);
            CC_LE:   p = z || (n != v);
            CC_AL:   p = 1'b1;
            default: p = 1'b0;
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/core/barrel_shift_alu_with_flags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barrel_shift_alu_with_flags
// Data-processing execute unit: condition check, barrel shifter, 16-op alu,
// register file r0..r14 plus program counter, and NZCV flags.
// ----------------------------------------------------------------------------
// path: request accept -> execute stage holding register (operand read) -> result register (execute)
// throughput: one request per cycle while m_tready does not stall the result, limited by the single execute pass
// the register file read feeding the execute pass is registered at accept
// reset (aresetn low, synchronous): registers read as zero, r15 = 8, flags zero,
// both channels empty
module barrel_shift_alu_with_flags (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bsalu_pkg::IN_TDATA_W-1:0]    s_tdata,  // [31:0] instruction
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] executed, [32:1] result_value, [36:33] dest_index, [37] wrote_register,
    // [41:38] flags_after, [42] unsupported, [47:43] zero
    output logic [bsalu_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import bsalu_pkg::*;

    // register file copies: a serves rn and rm, b serves rs
    logic [XLEN-1:0]        rf_a_reg [NUM_REGS];
    logic [XLEN-1:0]        rf_b_reg [NUM_REGS];
    logic [NUM_REGS-1:0]    rf_valid_reg;

    logic [XLEN-1:0]        pc_reg;
    logic [FLAGS_W-1:0]     flags_reg;

    // execute stage holding register
    logic                   in_valid_reg;
    logic [IN_TDATA_W-1:0]  ins_reg;
    logic [XLEN-1:0]        rn_data_reg, rm_data_reg, rs_data_reg;
    logic                   rn_ok_reg, rm_ok_reg, rs_ok_reg;

    // result register
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic [OUT_TDATA_W-1:0] m_data_next;

    logic                   s_accept;
    logic                   advance;

    // decoded fields
    logic [3:0]             cond;
    alu_op_t                op;
    logic                   sbit, ibit, reg_shift;
    logic [REG_IDX_W-1:0]   rn_idx, rd_idx, rs_idx, rm_idx;
    shift_t                 kind;
    logic [4:0]             imm_amt;
    logic                   dp, pass, executed, writes;

    // operands
    logic [XLEN-1:0]        pc_x;
    logic [XLEN-1:0]        a_val, rm_val, rs_val;
    logic [7:0]             amt8;
    logic                   rrx;
    logic [XLEN:0]          lsl_t, lsr_t;
    logic signed [XLEN:0]   asr_t;
    logic [5:0]             asr_amt;
    logic [2*XLEN-1:0]      ror_t;
    logic [2*XLEN-1:0]      imm_t;
    logic [4:0]             imm_rot;
    logic [XLEN-1:0]        b_val;
    logic                   sh_c;

    // alu
    logic                   arith;
    logic [XLEN-1:0]        ax, ay, r_val;
    logic                   cin;
    logic [XLEN:0]          sum;
    logic                   nf, zf, cf, vf;
    logic [FLAGS_W-1:0]     flags_new, flags_out;

    // write port
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   wr_idx;
    logic [XLEN-1:0]        wr_data;
    logic [REG_IDX_W-1:0]   s_rn, s_rm, s_rs;

    // handshakes
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign s_rn = s_tdata[19:16];
    assign s_rm = s_tdata[3:0];
    assign s_rs = s_tdata[11:8];

    // field decode
    always_comb begin
        cond      = ins_reg[31:28];
        op        = alu_op_t'(ins_reg[24:21]);
        sbit      = ins_reg[20];
        ibit      = ins_reg[25];
        rn_idx    = ins_reg[19:16];
        rd_idx    = ins_reg[15:12];
        rs_idx    = ins_reg[11:8];
        rm_idx    = ins_reg[3:0];
        kind      = shift_t'(ins_reg[6:5]);
        imm_amt   = ins_reg[11:7];
        reg_shift = !ibit && ins_reg[4];
        dp = (ins_reg[27:26] == 2'b00)
             && !((ins_reg[24:23] == 2'b10) && !sbit)
             && (ibit || !(ins_reg[7] && ins_reg[4]));
        pass     = cond_pass(cond, flags_reg);
        executed = dp && pass;
        writes   = (ins_reg[24:23] != 2'b10);
    end

    // operand selection, r15 reads the program counter
    always_comb begin
        pc_x   = reg_shift ? (pc_reg + PC_STEP) : pc_reg;
        a_val  = (rn_idx == PC_IDX) ? pc_x : (rn_ok_reg ? rn_data_reg : '0);
        rm_val = (rm_idx == PC_IDX) ? pc_x : (rm_ok_reg ? rm_data_reg : '0);
        rs_val = (rs_idx == PC_IDX) ? pc_reg : (rs_ok_reg ? rs_data_reg : '0);
    end

    // barrel shifter
    always_comb begin
        rrx  = !reg_shift && (imm_amt == 5'd0) && (kind == SH_ROR);
        if (reg_shift) begin
            amt8 = rs_val[7:0];
        end else if ((imm_amt == 5'd0) && (kind inside {SH_LSR, SH_ASR})) begin
            amt8 = 8'd32;
        end else begin
            amt8 = {3'b000, imm_amt};
        end
        lsl_t   = {1'b0, rm_val} << amt8;
        lsr_t   = {rm_val, 1'b0} >> amt8;
        asr_amt = (amt8 > 8'd32) ? 6'd32 : amt8[5:0];
        asr_t   = $signed({rm_val, 1'b0}) >>> asr_amt;
        ror_t   = {rm_val, rm_val} >> amt8[4:0];
        imm_rot = {ins_reg[11:8], 1'b0};
        imm_t   = {24'd0, ins_reg[7:0], 24'd0, ins_reg[7:0]} >> imm_rot;

        if (ibit) begin
            b_val = imm_t[XLEN-1:0];
            sh_c  = (imm_rot == 5'd0) ? flags_reg[1] : imm_t[XLEN-1];
        end else if (rrx) begin
            b_val = {flags_reg[1], rm_val[XLEN-1:1]};
            sh_c  = rm_val[0];
        end else if (amt8 == 8'd0) begin
            b_val = rm_val;
            sh_c  = flags_reg[1];
        end else begin
            case (kind)
                SH_LSL: begin
                    b_val = lsl_t[XLEN-1:0];
                    sh_c  = lsl_t[XLEN];
                end
                SH_LSR: begin
                    b_val = lsr_t[XLEN:1];
                    sh_c  = lsr_t[0];
                end
                SH_ASR: begin
                    b_val = asr_t[XLEN:1];
                    sh_c  = asr_t[0];
                end
                default: begin
                    b_val = ror_t[XLEN-1:0];
                    sh_c  = ror_t[XLEN-1];
                end
            endcase
        end
    end

    // alu and flags
    always_comb begin
        arith = 1'b1;
        ax    = a_val;
        ay    = b_val;
        cin   = 1'b0;
        r_val = '0;
        case (op)
            OP_AND, OP_TST: begin
                arith = 1'b0;
                r_val = a_val & b_val;
            end
            OP_EOR, OP_TEQ: begin
                arith = 1'b0;
                r_val = a_val ^ b_val;
            end
            OP_SUB, OP_CMP: begin
                ay  = ~b_val;
                cin = 1'b1;
            end
            OP_RSB: begin
                ax  = b_val;
                ay  = ~a_val;
                cin = 1'b1;
            end
            OP_ADD, OP_CMN: begin
                cin = 1'b0;
            end
            OP_ADC: begin
                cin = flags_reg[1];
            end
            OP_SBC: begin
                ay  = ~b_val;
                cin = flags_reg[1];
            end
            OP_RSC: begin
                ax  = b_val;
                ay  = ~a_val;
                cin = flags_reg[1];
            end
            OP_ORR: begin
                arith = 1'b0;
                r_val = a_val | b_val;
            end
            OP_MOV: begin
                arith = 1'b0;
                r_val = b_val;
            end
            OP_BIC: begin
                arith = 1'b0;
                r_val = a_val & ~b_val;
            end
            default: begin
                arith = 1'b0;
                r_val = ~b_val;
            end
        endcase

        sum = {1'b0, ax} + {1'b0, ay} + {{XLEN{1'b0}}, cin};
        if (arith) begin
            r_val = sum[XLEN-1:0];
            cf    = sum[XLEN];
            vf    = ((ax[XLEN-1] ^ sum[XLEN-1]) & (ay[XLEN-1] ^ sum[XLEN-1]));
        end else begin
            cf = sh_c;
            vf = flags_reg[0];
        end
        nf        = r_val[XLEN-1];
        zf        = (r_val == '0);
        flags_new = {nf, zf, cf, vf};
        flags_out = (executed && sbit) ? flags_new : flags_reg;
    end

    // register file write port
    assign wr_en   = advance && executed && writes && (rd_idx != PC_IDX);
    assign wr_idx  = rd_idx;
    assign wr_data = r_val;

    // result packing
    always_comb begin
        m_data_next        = '0;
        m_data_next[0]     = executed;
        m_data_next[32:1]  = executed ? r_val : '0;
        m_data_next[36:33] = executed ? rd_idx : '0;
        m_data_next[37]    = executed && writes;
        m_data_next[41:38] = flags_out;
        m_data_next[42]    = !dp;
    end

    // register file storage and operand read with write bypass
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rf_a_reg[wr_idx] <= wr_data;
            rf_b_reg[wr_idx] <= wr_data;
        end
        if (s_accept) begin
            rn_data_reg <= (wr_en && (wr_idx == s_rn)) ? wr_data : rf_a_reg[s_rn];
            rm_data_reg <= (wr_en && (wr_idx == s_rm)) ? wr_data : rf_a_reg[s_rm];
            rs_data_reg <= (wr_en && (wr_idx == s_rs)) ? wr_data : rf_b_reg[s_rs];
            rn_ok_reg   <= (wr_en && (wr_idx == s_rn)) || rf_valid_reg[s_rn];
            rm_ok_reg   <= (wr_en && (wr_idx == s_rm)) || rf_valid_reg[s_rm];
            rs_ok_reg   <= (wr_en && (wr_idx == s_rs)) || rf_valid_reg[s_rs];
            ins_reg     <= s_tdata;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    // control state: valid bits, program counter, flags, stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
            pc_reg       <= PC_RESET;
            flags_reg    <= '0;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                rf_valid_reg[wr_idx] <= 1'b1;
            end
            if (advance) begin
                flags_reg <= flags_out;
                if (executed && writes && (rd_idx == PC_IDX)) begin
                    pc_reg <= r_val + PC_AHEAD;
                end else begin
                    pc_reg <= pc_reg + PC_STEP;
                end
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: dv/barrel_shift_alu_with_flags_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barrel_shift_alu_with_flags_tb
// Drives data-processing instruction words into the execute unit and checks
// every result against an in-bench model of the register file, the barrel
// shifter, the alu and the NZCV flags. A directed opening covers each opcode,
// the shifter corner cases, condition failures, pc reads and writes, and
// words outside the data-processing space. Random words with random gaps and
// back-pressure follow.
// ----------------------------------------------------------------------------
module barrel_shift_alu_with_flags_tb;
    import bsalu_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_WORDS  = 1770;
    localparam int DRAIN_CYCLES  = 20;
    localparam int QUIET_LIMIT   = 1000;
    localparam int MAX_WAIT      = 18;

    // instruction class bits [27:26]
    localparam logic [1:0]  CLS_DATA_PROC  = 2'b00;
    localparam logic [1:0]  CLS_LOAD_STORE = 2'b01;
    // opcodes 8..11 share this top pair: compare and test group
    localparam logic [1:0]  TEST_GROUP     = 2'b10;
    // bits 7 and 4 both set in register form: multiply and extra load/store space
    localparam logic [11:0] MUL_SPACE_BITS = 12'h090;

    // one result, laid out as on m_tdata from bit 0 up
    typedef struct packed {
        logic                 unsupported;
        logic [FLAGS_W-1:0]   flags;
        logic                 wrote;
        logic [REG_IDX_W-1:0] dest;
        logic [XLEN-1:0]      value;
        logic                 executed;
    } outcome_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    bit req_streak = 1'b0;

    // ------------------------------------------------------------------------
    // execute model and result checker
    // ------------------------------------------------------------------------
    class alu_scoreboard;
        logic [XLEN-1:0]    regs [NUM_REGS];
        logic [FLAGS_W-1:0] nzcv;
        outcome_t           expected_outcomes [$];
        int requests, executed, skipped, outside_dp, branches, checked, failures;

        function new();
            foreach (regs[i]) regs[i] = '0;
            regs[PC_IDX] = PC_RESET;
            nzcv       = '0;
            requests   = 0;
            executed   = 0;
            skipped    = 0;
            outside_dp = 0;
            branches   = 0;
            checked    = 0;
            failures   = 0;
        endfunction

        function logic [XLEN-1:0] read_reg(logic [REG_IDX_W-1:0] idx, logic [XLEN-1:0] extra);
            return regs[idx] + ((idx == PC_IDX) ? extra : '0);
        endfunction

        function bit cond_holds(cond_t cc);
            logic n, z, c, v;
            {n, z, c, v} = nzcv;
            case (cc)
                CC_EQ:   return z;
                CC_NE:   return !z;
                CC_CS:   return c;
                CC_CC:   return !c;
                CC_MI:   return n;
                CC_PL:   return !n;
                CC_VS:   return v;
                CC_VC:   return !v;
                CC_HI:   return c && !z;
                CC_LS:   return !c || z;
                CC_GE:   return n == v;
                CC_LT:   return n != v;
                CC_GT:   return !z && (n == v);
                CC_LE:   return z || (n != v);
                CC_AL:   return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // amt of zero leaves the value and carry alone; amounts past 31 saturate the shifts and wrap the rotate
        function logic [XLEN-1:0] barrel_shift(logic [XLEN-1:0] v, shift_t kind,
                                               int unsigned amt, logic cin, output logic cout);
            logic signed [XLEN-1:0] sv;
            int unsigned            n;
            sv = v;
            n  = amt % 32;
            if (amt == 0) begin
                cout = cin;
                return v;
            end
            case (kind)
                SH_LSL: begin
                    if (amt < 32) begin
                        cout = v[32 - amt];
                        return v << amt;
                    end
                    cout = (amt == 32) ? v[0] : 1'b0;
                    return '0;
                end
                SH_LSR: begin
                    if (amt < 32) begin
                        cout = v[amt - 1];
                        return v >> amt;
                    end
                    cout = (amt == 32) ? v[31] : 1'b0;
                    return '0;
                end
                SH_ASR: begin
                    if (amt < 32) begin
                        cout = v[amt - 1];
                        return sv >>> amt;
                    end
                    cout = v[31];
                    return {XLEN{v[31]}};
                end
                default: begin
                    if (n == 0) begin
                        cout = v[31];
                        return v;
                    end
                    cout = v[n - 1];
                    return (v >> n) | (v << (32 - n));
                end
            endcase
        endfunction

        function outcome_t run_instruction(logic [IN_TDATA_W-1:0] w);
            outcome_t             o;
            alu_op_t              op;
            shift_t               kind;
            logic [REG_IDX_W-1:0] rn, rd;
            logic                 sbit, ibit, cflag, sh_c, cin, arith, writes, is_dp, cf, vf;
            logic [XLEN-1:0]      a, b, rm, rs_val, x, y, r, pc_extra;
            logic [2*XLEN-1:0]    twice;
            logic [XLEN:0]        sum;
            int unsigned          amt;

            op    = alu_op_t'(w[24:21]);
            kind  = shift_t'(w[6:5]);
            rn    = w[19:16];
            rd    = w[15:12];
            sbit  = w[20];
            ibit  = w[25];
            cflag = nzcv[1];
            o       = '0;
            o.flags = nzcv;
            requests++;

            // words outside the data-processing space only move the pc
            is_dp = (w[27:26] == CLS_DATA_PROC) && !(w[24:23] == TEST_GROUP && !sbit)
                    && (ibit || (w[11:0] & MUL_SPACE_BITS) != MUL_SPACE_BITS);
            if (!is_dp) begin
                o.unsupported = 1'b1;
                outside_dp++;
                regs[PC_IDX] += PC_STEP;
                return o;
            end
            if (!cond_holds(cond_t'(w[31:28]))) begin
                skipped++;
                regs[PC_IDX] += PC_STEP;
                return o;
            end

            // second operand
            pc_extra = '0;
            if (ibit) begin
                amt   = {w[11:8], 1'b0};
                twice = {2{24'd0, w[7:0]}};
                twice = twice >> amt;
                b     = twice[XLEN-1:0];
                sh_c  = (amt == 0) ? cflag : b[31];
            end else if (w[4]) begin
                // register amount: pc reads one word further ahead
                pc_extra = PC_STEP;
                rm       = read_reg(w[3:0], pc_extra);
                rs_val   = read_reg(w[11:8], '0);
                amt      = rs_val[7:0];
                b        = barrel_shift(rm, kind, amt, cflag, sh_c);
            end else begin
                amt = w[11:7];
                rm  = read_reg(w[3:0], '0);
                if (amt == 0 && kind == SH_ROR) begin
                    // rotate right through carry
                    sh_c = rm[0];
                    b    = {cflag, rm[31:1]};
                end else if (amt == 0 && (kind == SH_LSR || kind == SH_ASR)) begin
                    b = barrel_shift(rm, kind, 32, cflag, sh_c);
                end else begin
                    b = barrel_shift(rm, kind, amt, cflag, sh_c);
                end
            end
            a = read_reg(rn, pc_extra);

            // alu
            arith = 1'b1;
            x     = a;
            y     = b;
            cin   = 1'b0;
            r     = '0;
            case (op)
                OP_AND, OP_TST: begin
                    arith = 1'b0;
                    r     = a & b;
                end
                OP_EOR, OP_TEQ: begin
                    arith = 1'b0;
                    r     = a ^ b;
                end
                OP_SUB, OP_CMP: begin
                    y   = ~b;
                    cin = 1'b1;
                end
                OP_RSB: begin
                    x   = b;
                    y   = ~a;
                    cin = 1'b1;
                end
                OP_ADD, OP_CMN: cin = 1'b0;
                OP_ADC: cin = cflag;
                OP_SBC: begin
                    y   = ~b;
                    cin = cflag;
                end
                OP_RSC: begin
                    x   = b;
                    y   = ~a;
                    cin = cflag;
                end
                OP_ORR: begin
                    arith = 1'b0;
                    r     = a | b;
                end
                OP_MOV: begin
                    arith = 1'b0;
                    r     = b;
                end
                OP_BIC: begin
                    arith = 1'b0;
                    r     = a & ~b;
                end
                default: begin
                    arith = 1'b0;
                    r     = ~b;
                end
            endcase
            if (arith) begin
                sum = {1'b0, x} + {1'b0, y} + cin;
                r   = sum[XLEN-1:0];
                cf  = sum[XLEN];
                vf  = (x[31] ^ r[31]) & (y[31] ^ r[31]);
            end else begin
                cf = sh_c;
                vf = nzcv[0];
            end
            if (sbit)
                nzcv = {r[31], (r == '0), cf, vf};

            // write back; a write to r15 is a branch
            writes = (w[24:23] != TEST_GROUP);
            if (writes && rd == PC_IDX) begin
                regs[PC_IDX] = r + PC_AHEAD;
                branches++;
            end else begin
                if (writes)
                    regs[rd] = r;
                regs[PC_IDX] += PC_STEP;
            end
            executed++;

            o.executed = 1'b1;
            o.value    = r;
            o.dest     = rd;
            o.wrote    = writes;
            o.flags    = nzcv;
            return o;
        endfunction

        function void note_request(logic [IN_TDATA_W-1:0] w);
            expected_outcomes.push_back(run_instruction(w));
        endfunction

        function void compare_field(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
            if (got !== want) begin
                $error("%s mismatch on result %0d: expected %h, got %h", name, checked, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            outcome_t got, want;
            got = data[$bits(outcome_t)-1:0];
            checked++;
            if (expected_outcomes.size() == 0) begin
                $error("result %0d arrived with no request pending: %h", checked, data);
                failures++;
                return;
            end
            want = expected_outcomes.pop_front();
            compare_field("executed", want.executed, got.executed);
            compare_field("result_value", want.value, got.value);
            compare_field("dest_index", want.dest, got.dest);
            compare_field("wrote_register", want.wrote, got.wrote);
            compare_field("flags_after", want.flags, got.flags);
            compare_field("unsupported", want.unsupported, got.unsupported);
        endfunction
    endclass

    alu_scoreboard scoreboard;

    barrel_shift_alu_with_flags DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // instruction word builders
    // ------------------------------------------------------------------------
    function automatic logic [31:0] dp_word(cond_t cc, alu_op_t op, logic s,
                                            logic [3:0] rn, logic [3:0] rd,
                                            logic imm_form, logic [11:0] operand);
        return {cc, CLS_DATA_PROC, imm_form, op, s, rn, rd, operand};
    endfunction

    function automatic logic [11:0] imm_op(logic [3:0] rot, logic [7:0] imm8);
        return {rot, imm8};
    endfunction

    function automatic logic [11:0] sh_imm(logic [4:0] amt, shift_t kind, logic [3:0] rm);
        return {amt, kind, 1'b0, rm};
    endfunction

    function automatic logic [11:0] sh_reg(logic [3:0] rs, shift_t kind, logic [3:0] rm);
        return {rs, 1'b0, kind, 1'b1, rm};
    endfunction

    // mostly well-formed words, some register seeding with small values, some noise
    function automatic logic [31:0] random_request();
        int          pick;
        cond_t       cc;
        alu_op_t     op;
        logic        s, imm_form;
        logic [11:0] operand;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return $urandom();
        if (pick < 27)
            return dp_word(CC_AL, OP_MOV, 1'($urandom_range(0, 1)), 4'($urandom),
                           4'($urandom_range(0, 14)), 1'b1,
                           imm_op(4'd0, 8'($urandom_range(0, 40))));
        cc = ($urandom_range(0, 9) < 6) ? CC_AL : cond_t'($urandom_range(0, 15));
        op = alu_op_t'($urandom_range(0, 15));
        s  = (op >= OP_TST && op <= OP_CMN) ? 1'b1 : 1'($urandom_range(0, 1));
        case ($urandom_range(0, 2))
            0: begin
                imm_form = 1'b1;
                operand  = 12'($urandom);
            end
            1: begin
                imm_form = 1'b0;
                operand  = sh_imm(5'($urandom), shift_t'($urandom_range(0, 3)), 4'($urandom));
            end
            default: begin
                imm_form = 1'b0;
                operand  = sh_reg(4'($urandom), shift_t'($urandom_range(0, 3)), 4'($urandom));
            end
        endcase
        return dp_word(cc, op, s, 4'($urandom), 4'($urandom), imm_form, operand);
    endfunction

    // per-request wait, with occasional runs of back-to-back traffic
    function automatic int draw_wait(inout bit streak);
        if ($urandom_range(0, 29) == 0)
            streak = !streak;
        return streak ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic send_request(input logic [IN_TDATA_W-1:0] word);
        int gap;
        gap = draw_wait(req_streak);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    // ------------------------------------------------------------------------
    // handshake monitor
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            scoreboard.note_request(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            scoreboard.check_result(m_tdata);
    end

    // result sink with random back-pressure
    initial begin : result_sink
        bit rsp_streak;
        int stall;
        rsp_streak = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_wait(rsp_streak);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ends the run if traffic stops moving
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("barrel_shift_alu_with_flags_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] opening_words [$];

        scoreboard = new();

        // seed a few registers: 0x80000000, 1, 32, all ones
        opening_words.push_back(dp_word(CC_AL, OP_MOV, 1'b1, 4'd0, 4'd1, 1'b1, imm_op(4'd1, 8'd2)));
        opening_words.push_back(dp_word(CC_AL, OP_MOV, 1'b0, 4'd0, 4'd2, 1'b1, imm_op(4'd0, 8'd1)));
        opening_words.push_back(dp_word(CC_AL, OP_MOV, 1'b0, 4'd0, 4'd3, 1'b1, imm_op(4'd0, 8'd32)));
        opening_words.push_back(dp_word(CC_AL, OP_MVN, 1'b1, 4'd0, 4'd4, 1'b1, imm_op(4'd0, 8'd0)));
        // signed overflow to zero, then add with carry in
        opening_words.push_back(dp_word(CC_AL, OP_ADD, 1'b1, 4'd1, 4'd6, 1'b0,
                                        sh_imm(5'd0, SH_LSL, 4'd1)));
        opening_words.push_back(dp_word(CC_AL, OP_ADC, 1'b1, 4'd2, 4'd7, 1'b0,
                                        sh_imm(5'd0, SH_LSL, 4'd2)));
        // register shifts by exactly 32, by 255, and by zero
        opening_words.push_back(dp_word(CC_AL, OP_MOV, 1'b1, 4'd0, 4'd8, 1'b0,
                                        sh_reg(4'd3, SH_LSL, 4'd2)));
        opening_words.push_back(dp_word(CC_AL, OP_MOV, 1'b1, 4'd0, 4'd9, 1'b0,
                                        sh_reg(4'd3, SH_LSR, 4'd1)));
        opening_words.push_back(dp_word(CC_AL, OP_AND, 1'b1, 4'd4, 4'd10, 1'b0,
                                        sh_reg(4'd4, SH_LSL, 4'd1)));
        opening_words.push_back(dp_word(CC_AL, OP_EOR, 1'b1, 4'd2, 4'd11, 1'b0,
                                        sh_reg(4'd4, SH_ASR, 4'd1)));
        opening_words.push_back(dp_word(CC_AL, OP_ORR, 1'b1, 4'd2, 4'd12, 1'b0,
                                        sh_reg(4'd3, SH_ROR, 4'd1)));
        opening_words.push_back(dp_word(CC_AL, OP_BIC, 1'b1, 4'd4, 4'd5, 1'b0,
                                        sh_reg(4'd0, SH_LSL, 4'd2)));
        // immediate-amount encodings of rrx, asr #32 and lsr #32
        opening_words.push_back(dp_word(CC_AL, OP_RSB, 1'b1, 4'd2, 4'd13, 1'b0,
                                        sh_imm(5'd0, SH_ROR, 4'd1)));
        opening_words.push_back(dp_word(CC_AL, OP_SUB, 1'b1, 4'd2, 4'd0, 1'b0,
                                        sh_imm(5'd0, SH_ASR, 4'd1)));
        opening_words.push_back(dp_word(CC_AL, OP_SBC, 1'b1, 4'd4, 4'd14, 1'b0,
                                        sh_imm(5'd0, SH_LSR, 4'd1)));
        opening_words.push_back(dp_word(CC_AL, OP_RSC, 1'b1, 4'd3, 4'd0, 1'b1,
                                        imm_op(4'd0, 8'hFF)));
        // compare and test group, leaving Z and C set
        opening_words.push_back(dp_word(CC_AL, OP_TST, 1'b1, 4'd4, 4'd0, 1'b1,
                                        imm_op(4'd0, 8'd0)));
        opening_words.push_back(dp_word(CC_AL, OP_TEQ, 1'b1, 4'd1, 4'd0, 1'b0,
                                        sh_imm(5'd0, SH_LSL, 4'd1)));
        opening_words.push_back(dp_word(CC_AL, OP_CMP, 1'b1, 4'd2, 4'd0, 1'b0,
                                        sh_imm(5'd0, SH_LSL, 4'd3)));
        opening_words.push_back(dp_word(CC_AL, OP_CMN, 1'b1, 4'd4, 4'd0, 1'b0,
                                        sh_imm(5'd0, SH_LSL, 4'd2)));
        // failed condition and the never condition
        opening_words.push_back(dp_word(CC_NE, OP_ADD, 1'b0, 4'd2, 4'd5, 1'b0,
                                        sh_imm(5'd0, SH_LSL, 4'd2)));
        opening_words.push_back(dp_word(CC_NV, OP_MOV, 1'b0, 4'd0, 4'd5, 1'b1,
                                        imm_op(4'd0, 8'd1)));
        // pc as operands with a register amount, then pc as destination
        opening_words.push_back(dp_word(CC_AL, OP_ADD, 1'b0, PC_IDX, 4'd6, 1'b0,
                                        sh_reg(4'd2, SH_LSL, PC_IDX)));
        opening_words.push_back(dp_word(CC_AL, OP_ADD, 1'b1, PC_IDX, PC_IDX, 1'b1,
                                        imm_op(4'd0, 8'd0)));
        // outside the data-processing space: other class, test without S, multiply space
        opening_words.push_back({CC_AL, CLS_LOAD_STORE, 26'h0123456});
        opening_words.push_back(dp_word(CC_AL, OP_TST, 1'b0, 4'd1, 4'd0, 1'b0,
                                        sh_imm(5'd0, SH_LSL, 4'd2)));
        opening_words.push_back(dp_word(CC_AL, OP_ADD, 1'b0, 4'd1, 4'd2, 1'b0,
                                        sh_reg(4'd3, SH_LSL, 4'd5) | MUL_SPACE_BITS));
        // all-zero and all-one words
        opening_words.push_back(32'h0000_0000);
        opening_words.push_back(32'hFFFF_FFFF);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening_words[i])
            send_request(opening_words[i]);
        repeat (RANDOM_WORDS)
            send_request(random_request());
        s_tvalid <= 1'b0;

        // let every pending result drain, then watch for stray ones
        while (scoreboard.expected_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d requests: %0d executed, %0d held back by condition,",
                 scoreboard.requests, scoreboard.executed, scoreboard.skipped);
        $display("%0d not data processing, %0d results checked, %0d writes to the pc, %0d mismatches",
                 scoreboard.outside_dp, scoreboard.checked, scoreboard.branches,
                 scoreboard.failures);
        if (scoreboard.failures == 0)
            $display("barrel_shift_alu_with_flags_tb OK");
        else
            $display("barrel_shift_alu_with_flags_tb NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/bsalu_pkg.sv
rtl/core/barrel_shift_alu_with_flags.sv
dv/barrel_shift_alu_with_flags_tb.sv
